// ===== rtl/core/sps_pkg.sv =====
// -----------------------------------------------------------------------------
// sps_pkg
// Shared widths, codes and stage records for the sphere collision pipeline.
// -----------------------------------------------------------------------------
package sps_pkg;

    localparam int COORD_W   = 32;  // coordinate width, Q16.16
    localparam int FRAC_W    = 16;  // fraction bits
    localparam int RAD_W     = 31;  // radius and depth width
    localparam int NRM_W     = 18;  // normal component width
    localparam int MAG_W     = 32;  // magnitude of a center difference
    localparam int SQ_W      = 64;  // exact square of a magnitude
    localparam int SUM_W     = 66;  // sum of three squares before saturation
    localparam int PL_W      = 51;  // plane distance sum
    localparam int POS_W     = 5;   // bit position inside a magnitude
    localparam int UM_W      = 30;  // normalized magnitude width
    localparam int UNIT_MSB  = UM_W - 1;
    localparam int USQ_W     = 2 * UM_W;
    localparam int USUM_W    = USQ_W + 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIVP_W    = ROOT_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic [NRM_W-1:0]          NRM_ONE   = NRM_W'(1 << FRAC_W);
    localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1 << FRAC_W);

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_PLANE  = 2'd2,
        CMD_CYL    = 2'd3
    } t_cmd;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [2:0][COORD_W-1:0] c1;
        logic [2:0][COORD_W-1:0] c2;
        logic [RAD_W-1:0]        r1;
        logic [RAD_W-1:0]        r2;
        logic [1:0]              axis;
        logic [COORD_W-1:0]      ext;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic                  use_unit;
        logic                  zero_vec;
        logic [2:0]            neg;
        logic [RAD_W-1:0]      pen;
        logic [2:0][NRM_W-1:0] pn;
    } t_side;

    typedef struct packed {
        t_cmd                    cmd;
        logic                    span_ok;
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0]              neg;
        logic [2:0][COORD_W-1:0] c1;
        logic [2:0][COORD_W-1:0] c2;
        logic [COORD_W-1:0]      ext;
        logic [RAD_W-1:0]        r1;
        logic [RAD_W:0]          rs;
        logic [RAD_W-1:0]        rd;
        logic [2:0][NRM_W-1:0]   pn;
    } t_s1;

    typedef struct packed {
        t_cmd                  cmd;
        logic                  span_ok;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [2:0][SQ_W-1:0]  sq;
        logic [SQ_W-1:0]       rs2;
        logic [SQ_W-1:0]       rd2;
        logic [2:0][SQ_W-1:0]  pp;
        logic [COORD_W-1:0]    ext;
        logic [RAD_W-1:0]      r1;
        logic [2:0][NRM_W-1:0] pn;
    } t_s2;

    typedef struct packed {
        t_side                 side;
        logic [SQ_W-1:0]       rad;
        logic [2:0][MAG_W-1:0] mag;
        logic                  sh_right;
        logic [POS_W-1:0]      sh_amt;
    } t_s3;

    typedef struct packed {
        t_side                side;
        logic [SQ_W-1:0]      rad;
        logic [2:0][UM_W-1:0] m;
    } t_s4;

    typedef struct packed {
        t_side                 side;
        logic [SQ_W-1:0]       rad;
        logic [2:0][UM_W-1:0]  m;
        logic [2:0][USQ_W-1:0] msq;
    } t_s5;

    typedef struct packed {
        t_side                side;
        logic [SQ_W-1:0]      rad;
        logic [2:0][UM_W-1:0] m;
        logic [USUM_W-1:0]    sum;
    } t_s6;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        t_sqrt                pen;
        t_sqrt                len;
        logic [2:0][UM_W-1:0] m;
        t_side                side;
    } t_sq_cell;

    typedef struct packed {
        logic [DIVP_W-1:0] p;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  q;
    } t_div;

    typedef struct packed {
        t_div [2:0]        lane;
        logic [ROOT_W-1:0] len;
        t_side             side;
    } t_dv_cell;

endpackage

// ===== rtl/core/sps_if.sv =====
// -----------------------------------------------------------------------------
// sps_if
// Request and response channels of the sphere collision block.
// -----------------------------------------------------------------------------
interface sps_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       cmd;
    logic signed [sps_pkg::COORD_W-1:0] sphere_x;
    logic signed [sps_pkg::COORD_W-1:0] sphere_y;
    logic signed [sps_pkg::COORD_W-1:0] sphere_z;
    logic signed [sps_pkg::COORD_W-1:0] other_x;
    logic signed [sps_pkg::COORD_W-1:0] other_y;
    logic signed [sps_pkg::COORD_W-1:0] other_z;
    logic [sps_pkg::RAD_W-1:0]        sphere_radius;
    logic [sps_pkg::RAD_W-1:0]        other_radius;
    logic [1:0]                       cyl_axis;
    logic signed [sps_pkg::COORD_W-1:0] extent;

    modport source (
        output valid, cmd, sphere_x, sphere_y, sphere_z, other_x, other_y, other_z,
               sphere_radius, other_radius, cyl_axis, extent,
        input  ready
    );
    modport sink (
        input  valid, cmd, sphere_x, sphere_y, sphere_z, other_x, other_y, other_z,
               sphere_radius, other_radius, cyl_axis, extent,
        output ready
    );
endinterface

interface sps_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [sps_pkg::RAD_W-1:0]        penetration;
    logic signed [sps_pkg::NRM_W-1:0] contact_nx;
    logic signed [sps_pkg::NRM_W-1:0] contact_ny;
    logic signed [sps_pkg::NRM_W-1:0] contact_nz;

    modport source (
        output valid, hit, penetration, contact_nx, contact_ny, contact_nz,
        input  ready
    );
    modport sink (
        input  valid, hit, penetration, contact_nx, contact_ny, contact_nz,
        output ready
    );
endinterface

// ===== rtl/core/sps_front.sv =====
// -----------------------------------------------------------------------------
// sps_front
// Six front stages: differences, products, hit tests and vector normalizing.
// -----------------------------------------------------------------------------
module sps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  sps_pkg::t_req   i_req,
    output logic            o_vld,
    output sps_pkg::t_s6    o_s6
);

    sps_pkg::t_s1 r_s1, n_s1;
    sps_pkg::t_s2 r_s2, n_s2;
    sps_pkg::t_s3 r_s3, n_s3;
    sps_pkg::t_s4 r_s4, n_s4;
    sps_pkg::t_s5 r_s5, n_s5;
    sps_pkg::t_s6 r_s6, n_s6;
    logic [5:0]   r_vld;

    logic signed [sps_pkg::COORD_W:0]   w_d [3];
    logic signed [sps_pkg::COORD_W+1:0] w_lo, w_hi, w_ca;
    logic signed [sps_pkg::COORD_W-1:0] w_c1a, w_c2a;
    logic                               w_axis_ok;

    logic [sps_pkg::SUM_W-1:0]        w_sum;
    logic [sps_pkg::SQ_W-1:0]         w_d2;
    logic signed [sps_pkg::PL_W-1:0]  w_s, w_r1s, w_plpen;
    logic [sps_pkg::RAD_W-1:0]        w_plpen_sat;
    logic [sps_pkg::MAG_W-1:0]        w_mx;
    logic [sps_pkg::POS_W-1:0]        w_pos;

    // Stage 1: center differences, axial span and radius sums.
    always_comb begin
        n_s1     = '0;
        n_s1.cmd = sps_pkg::t_cmd'(i_req.cmd);
        n_s1.c1  = i_req.c1;
        n_s1.c2  = i_req.c2;
        n_s1.ext = i_req.ext;
        n_s1.r1  = i_req.r1;
        n_s1.rs  = {1'b0, i_req.r1} + {1'b0, i_req.r2};
        n_s1.rd  = (i_req.r2 >= i_req.r1) ? (i_req.r2 - i_req.r1) : (i_req.r1 - i_req.r2);
        for (int i = 0; i < 3; i++) begin
            w_d[i] = $signed({i_req.c1[i][sps_pkg::COORD_W-1], i_req.c1[i]})
                   - $signed({i_req.c2[i][sps_pkg::COORD_W-1], i_req.c2[i]});
            n_s1.neg[i] = w_d[i][sps_pkg::COORD_W];
            n_s1.mag[i] = w_d[i][sps_pkg::COORD_W] ? sps_pkg::MAG_W'(-w_d[i])
                                                    : sps_pkg::MAG_W'(w_d[i]);
            // The cylinder's radial vector drops its axial component.
            if (n_s1.cmd == sps_pkg::CMD_CYL && i_req.axis == 2'(i)) begin
                n_s1.neg[i] = 1'b0;
                n_s1.mag[i] = '0;
            end
            if (n_s1.cmd == sps_pkg::CMD_PLANE) begin
                if ($signed(i_req.c2[i]) > sps_pkg::COORD_ONE) begin
                    n_s1.pn[i] = sps_pkg::NRM_ONE;
                end else if ($signed(i_req.c2[i]) < -sps_pkg::COORD_ONE) begin
                    n_s1.pn[i] = -sps_pkg::NRM_ONE;
                end else begin
                    n_s1.pn[i] = i_req.c2[i][sps_pkg::NRM_W-1:0];
                end
            end
        end
        w_axis_ok = 1'b1;
        unique case (i_req.axis)
            sps_pkg::AXIS_X: begin
                w_c1a = $signed(i_req.c1[0]);
                w_c2a = $signed(i_req.c2[0]);
            end
            sps_pkg::AXIS_Y: begin
                w_c1a = $signed(i_req.c1[1]);
                w_c2a = $signed(i_req.c2[1]);
            end
            sps_pkg::AXIS_Z: begin
                w_c1a = $signed(i_req.c1[2]);
                w_c2a = $signed(i_req.c2[2]);
            end
            default: begin
                w_c1a     = '0;
                w_c2a     = '0;
                w_axis_ok = 1'b0;
            end
        endcase
        w_lo = (sps_pkg::COORD_W+2)'(w_c2a) - (sps_pkg::COORD_W+2)'($signed(i_req.ext));
        w_hi = (sps_pkg::COORD_W+2)'(w_c2a) + (sps_pkg::COORD_W+2)'($signed(i_req.ext));
        w_ca = (sps_pkg::COORD_W+2)'(w_c1a);
        n_s1.span_ok = w_axis_ok && (w_ca >= w_lo) && (w_ca <= w_hi);
    end

    // Stage 2: all products in parallel.
    always_comb begin
        n_s2         = '0;
        n_s2.cmd     = r_s1.cmd;
        n_s2.span_ok = r_s1.span_ok;
        n_s2.mag     = r_s1.mag;
        n_s2.neg     = r_s1.neg;
        n_s2.ext     = r_s1.ext;
        n_s2.r1      = r_s1.r1;
        n_s2.pn      = r_s1.pn;
        n_s2.rs2     = sps_pkg::SQ_W'(r_s1.rs) * sps_pkg::SQ_W'(r_s1.rs);
        n_s2.rd2     = sps_pkg::SQ_W'(r_s1.rd) * sps_pkg::SQ_W'(r_s1.rd);
        for (int i = 0; i < 3; i++) begin
            n_s2.sq[i] = sps_pkg::SQ_W'(r_s1.mag[i]) * sps_pkg::SQ_W'(r_s1.mag[i]);
            n_s2.pp[i] = sps_pkg::SQ_W'($signed(r_s1.c1[i]) * $signed(r_s1.c2[i]));
        end
    end

    // Stage 3: hit decision, depth radicand and normalizing shift.
    always_comb begin
        n_s3      = '0;
        w_sum     = sps_pkg::SUM_W'(r_s2.sq[0]) + sps_pkg::SUM_W'(r_s2.sq[1])
                  + sps_pkg::SUM_W'(r_s2.sq[2]);
        w_d2      = (|w_sum[sps_pkg::SUM_W-1:sps_pkg::SQ_W]) ? '1 : w_sum[sps_pkg::SQ_W-1:0];
        w_s       = sps_pkg::PL_W'($signed(r_s2.ext))
                  + sps_pkg::PL_W'($signed(r_s2.pp[0][sps_pkg::SQ_W-1:sps_pkg::FRAC_W]))
                  + sps_pkg::PL_W'($signed(r_s2.pp[1][sps_pkg::SQ_W-1:sps_pkg::FRAC_W]))
                  + sps_pkg::PL_W'($signed(r_s2.pp[2][sps_pkg::SQ_W-1:sps_pkg::FRAC_W]));
        w_r1s     = sps_pkg::PL_W'($signed({1'b0, r_s2.r1}));
        w_plpen   = w_r1s - w_s;
        w_plpen_sat = (|w_plpen[sps_pkg::PL_W-1:sps_pkg::RAD_W]) ? '1
                    : w_plpen[sps_pkg::RAD_W-1:0];

        n_s3.mag      = r_s2.mag;
        n_s3.side.neg = r_s2.neg;
        n_s3.side.pn  = r_s2.pn;
        unique case (r_s2.cmd)
            sps_pkg::CMD_NONE: begin
                n_s3.side.hit = 1'b0;
            end
            sps_pkg::CMD_SPHERE: begin
                n_s3.side.hit      = w_d2 < r_s2.rs2;
                n_s3.side.use_unit = 1'b1;
                n_s3.rad           = r_s2.rs2 - w_d2;
            end
            sps_pkg::CMD_PLANE: begin
                n_s3.side.hit = w_s < w_r1s;
                n_s3.side.pen = w_plpen_sat;
            end
            sps_pkg::CMD_CYL: begin
                n_s3.side.hit      = r_s2.span_ok && (w_d2 > r_s2.rd2);
                n_s3.side.use_unit = 1'b1;
                n_s3.rad           = w_d2 - r_s2.rd2;
            end
        endcase

        w_mx = r_s2.mag[0];
        if (r_s2.mag[1] > w_mx) w_mx = r_s2.mag[1];
        if (r_s2.mag[2] > w_mx) w_mx = r_s2.mag[2];
        w_pos = '0;
        for (int b = 0; b < sps_pkg::MAG_W; b++) begin
            if (w_mx[b]) w_pos = sps_pkg::POS_W'(b);
        end
        n_s3.side.zero_vec = (w_mx == '0);
        // Bring the largest magnitude to the top bit of the unit mantissa.
        if (w_pos >= sps_pkg::POS_W'(sps_pkg::UNIT_MSB)) begin
            n_s3.sh_right = 1'b1;
            n_s3.sh_amt   = w_pos - sps_pkg::POS_W'(sps_pkg::UNIT_MSB);
        end else begin
            n_s3.sh_right = 1'b0;
            n_s3.sh_amt   = sps_pkg::POS_W'(sps_pkg::UNIT_MSB) - w_pos;
        end
    end

    // Stages 4 to 6: shift, square and sum the normalized components.
    always_comb begin
        n_s4      = '0;
        n_s4.side = r_s3.side;
        n_s4.rad  = r_s3.rad;
        for (int i = 0; i < 3; i++) begin
            n_s4.m[i] = r_s3.sh_right ? sps_pkg::UM_W'(r_s3.mag[i] >> r_s3.sh_amt)
                                      : sps_pkg::UM_W'(r_s3.mag[i] << r_s3.sh_amt);
        end
        n_s5      = '0;
        n_s5.side = r_s4.side;
        n_s5.rad  = r_s4.rad;
        n_s5.m    = r_s4.m;
        for (int i = 0; i < 3; i++) begin
            n_s5.msq[i] = sps_pkg::USQ_W'(r_s4.m[i]) * sps_pkg::USQ_W'(r_s4.m[i]);
        end
        n_s6      = '0;
        n_s6.side = r_s5.side;
        n_s6.rad  = r_s5.rad;
        n_s6.m    = r_s5.m;
        n_s6.sum  = sps_pkg::USUM_W'(r_s5.msq[0]) + sps_pkg::USUM_W'(r_s5.msq[1])
                  + sps_pkg::USUM_W'(r_s5.msq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
        end
    end

    assign o_vld = r_vld[5];
    assign o_s6  = r_s6;

endmodule

// ===== rtl/core/sps_sqrt_cell.sv =====
// -----------------------------------------------------------------------------
// sps_sqrt_cell
// One digit step of two integer square roots, radicand pairs shift along.
// -----------------------------------------------------------------------------
module sps_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  sps_pkg::t_sq_cell i_cell,
    output logic              o_vld,
    output sps_pkg::t_sq_cell o_cell
);

    sps_pkg::t_sq_cell r_cell, n_cell;
    logic              r_vld;

    function automatic sps_pkg::t_sqrt root_step(input sps_pkg::t_sqrt a);
        logic [sps_pkg::REM_W-1:0] r;
        logic [sps_pkg::REM_W-1:0] t;
        sps_pkg::t_sqrt            b;
        r = {a.rem[sps_pkg::REM_W-3:0], a.rad[sps_pkg::SQ_W-1 -: 2]};
        t = {a.root, 2'b01};
        b.rad = a.rad << 2;
        if (r >= t) begin
            b.rem  = r - t;
            b.root = {a.root[sps_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = r;
            b.root = {a.root[sps_pkg::ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    always_comb begin
        n_cell     = i_cell;
        n_cell.pen = root_step(i_cell.pen);
        n_cell.len = root_step(i_cell.len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== rtl/core/sps_div_cell.sv =====
// -----------------------------------------------------------------------------
// sps_div_cell
// One quotient bit of three restoring divisions by the vector length.
// -----------------------------------------------------------------------------
module sps_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  sps_pkg::t_dv_cell i_cell,
    output logic              o_vld,
    output sps_pkg::t_dv_cell o_cell
);

    sps_pkg::t_dv_cell r_cell, n_cell;
    logic              r_vld;

    function automatic sps_pkg::t_div div_step(input sps_pkg::t_div a,
                                               input logic [sps_pkg::ROOT_W-1:0] d);
        logic [sps_pkg::DIVP_W-1:0] p;
        sps_pkg::t_div              b;
        p     = {a.p[sps_pkg::DIVP_W-2:0], a.num[sps_pkg::QUO_W-1]};
        b.num = a.num << 1;
        if (p >= d) begin
            b.p = p - d;
            b.q = {a.q[sps_pkg::QUO_W-2:0], 1'b1};
        end else begin
            b.p = p;
            b.q = {a.q[sps_pkg::QUO_W-2:0], 1'b0};
        end
        return b;
    endfunction

    always_comb begin
        n_cell = i_cell;
        for (int i = 0; i < 3; i++) begin
            n_cell.lane[i] = div_step(i_cell.lane[i], i_cell.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== rtl/core/sphere_primitive_collision_test.sv =====
// A result passes the front stages, both cell chains and the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// stalls only while the output register holds a result that is not taken.
// Sphere and cylinder depth comes from a 32-cell square root chain, the normal from
// a second root of it and a 17-cell divider chain; planes use the front stages.
// Reset (synchronous, active low) clears all valid bits; no requests are lost after.
// -----------------------------------------------------------------------------
// sphere_primitive_collision_test
// Sphere against sphere, plane or axis-aligned inner cylinder contact test.
// -----------------------------------------------------------------------------
module sphere_primitive_collision_test (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sps_req_if.sink    i_req,
    sps_rsp_if.source  o_rsp
);

    logic              w_en;
    sps_pkg::t_req     w_req;
    logic              w_front_vld;
    sps_pkg::t_s6      w_s6;

    sps_pkg::t_sq_cell w_sq     [sps_pkg::SQRT_STEPS+1];
    logic [sps_pkg::SQRT_STEPS:0] w_sq_vld;
    sps_pkg::t_dv_cell w_dv     [sps_pkg::DIV_STEPS+1];
    logic [sps_pkg::DIV_STEPS:0]  w_dv_vld;

    logic [sps_pkg::NRM_W-1:0]    w_q    [3];
    logic [sps_pkg::NRM_W-1:0]    w_n    [3];

    logic                         r_out_vld;
    logic                         r_hit;
    logic [sps_pkg::RAD_W-1:0]    r_pen;
    logic [sps_pkg::NRM_W-1:0]    r_n    [3];
    logic [sps_pkg::NRM_W-1:0]    n_n    [3];
    logic                         n_hit;
    logic [sps_pkg::RAD_W-1:0]    n_pen;

    // The pipeline advances whenever the output register is free or drained.
    assign w_en        = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_en;

    always_comb begin
        w_req.cmd   = i_req.cmd;
        w_req.c1[0] = i_req.sphere_x;
        w_req.c1[1] = i_req.sphere_y;
        w_req.c1[2] = i_req.sphere_z;
        w_req.c2[0] = i_req.other_x;
        w_req.c2[1] = i_req.other_y;
        w_req.c2[2] = i_req.other_z;
        w_req.r1    = i_req.sphere_radius;
        w_req.r2    = i_req.other_radius;
        w_req.axis  = i_req.cyl_axis;
        w_req.ext   = i_req.extent;
    end

    sps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_req.valid && w_en),
        .i_req   (w_req),
        .o_vld   (w_front_vld),
        .o_s6    (w_s6)
    );

    always_comb begin
        w_sq[0]          = '0;
        w_sq[0].pen.rad  = w_s6.rad;
        w_sq[0].len.rad  = sps_pkg::SQ_W'(w_s6.sum);
        w_sq[0].m        = w_s6.m;
        w_sq[0].side     = w_s6.side;
        w_sq_vld[0]      = w_front_vld;
    end

    for (genvar g = 0; g < sps_pkg::SQRT_STEPS; g++) begin : g_sqrt
        sps_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_sq_vld[g]),
            .i_cell  (w_sq[g]),
            .o_vld   (w_sq_vld[g+1]),
            .o_cell  (w_sq[g+1])
        );
    end

    // Set up the divisions: numerator is the mantissa shifted up by the fraction.
    always_comb begin
        w_dv[0]      = '0;
        w_dv[0].len  = w_sq[sps_pkg::SQRT_STEPS].len.root;
        w_dv[0].side = w_sq[sps_pkg::SQRT_STEPS].side;
        if (w_sq[sps_pkg::SQRT_STEPS].side.use_unit) begin
            w_dv[0].side.pen = w_sq[sps_pkg::SQRT_STEPS].pen.root[sps_pkg::ROOT_W-1] ? '1
                : w_sq[sps_pkg::SQRT_STEPS].pen.root[sps_pkg::RAD_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            w_dv[0].lane[i].p   = sps_pkg::DIVP_W'(
                w_sq[sps_pkg::SQRT_STEPS].m[i][sps_pkg::UM_W-1:1]);
            w_dv[0].lane[i].num = {w_sq[sps_pkg::SQRT_STEPS].m[i][0],
                                   (sps_pkg::QUO_W-1)'(0)};
            w_dv[0].lane[i].q   = '0;
        end
        w_dv_vld[0] = w_sq_vld[sps_pkg::SQRT_STEPS];
    end

    for (genvar g = 0; g < sps_pkg::DIV_STEPS; g++) begin : g_div
        sps_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dv_vld[g]),
            .i_cell  (w_dv[g]),
            .o_vld   (w_dv_vld[g+1]),
            .o_cell  (w_dv[g+1])
        );
    end

    always_comb begin
        n_hit = w_dv[sps_pkg::DIV_STEPS].side.hit;
        n_pen = n_hit ? w_dv[sps_pkg::DIV_STEPS].side.pen : '0;
        for (int i = 0; i < 3; i++) begin
            w_q[i] = sps_pkg::NRM_W'(w_dv[sps_pkg::DIV_STEPS].lane[i].q);
            w_n[i] = w_dv[sps_pkg::DIV_STEPS].side.neg[i] ? -w_q[i] : w_q[i];
            if (!n_hit) begin
                n_n[i] = '0;
            end else if (!w_dv[sps_pkg::DIV_STEPS].side.use_unit) begin
                n_n[i] = w_dv[sps_pkg::DIV_STEPS].side.pn[i];
            end else if (w_dv[sps_pkg::DIV_STEPS].side.zero_vec) begin
                n_n[i] = '0;
            end else begin
                n_n[i] = w_n[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld[sps_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= n_hit;
            r_pen <= n_pen;
            r_n   <= n_n;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.penetration = r_pen;
    assign o_rsp.contact_nx  = r_n[0];
    assign o_rsp.contact_ny  = r_n[1];
    assign o_rsp.contact_nz  = r_n[2];

endmodule

// ===== rtl/core/sps_checker.sv =====
// -----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the collision results, bound to the top level.
// -----------------------------------------------------------------------------
module sps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             i_ready,
    input logic                             i_hit,
    input logic [sps_pkg::RAD_W-1:0]        i_pen,
    input logic signed [sps_pkg::NRM_W-1:0] i_nx,
    input logic signed [sps_pkg::NRM_W-1:0] i_ny,
    input logic signed [sps_pkg::NRM_W-1:0] i_nz
);

    localparam logic signed [sps_pkg::NRM_W-1:0] ONE = sps_pkg::NRM_ONE;

    // A miss carries no depth and no normal.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_pen == '0 && i_nx == '0 && i_ny == '0 && i_nz == '0)
        else $error("miss with nonzero payload");

    // Every overlap has a strictly positive depth.
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_hit |-> i_pen != '0)
        else $error("hit with zero depth");

    // Normal components never leave the unit range.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_nx <= ONE && i_nx >= -ONE && i_ny <= ONE && i_ny >= -ONE
                    && i_nz <= ONE && i_nz >= -ONE)
        else $error("normal component out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_hit) && $stable(i_pen)
                                && $stable(i_nx) && $stable(i_ny) && $stable(i_nz))
        else $error("stalled response changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("response valid right after reset");

endmodule

bind sphere_primitive_collision_test sps_checker u_sps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_hit   (o_rsp.hit),
    .i_pen   (o_rsp.penetration),
    .i_nx    (o_rsp.contact_nx),
    .i_ny    (o_rsp.contact_ny),
    .i_nz    (o_rsp.contact_nz)
);
